>>> rtl/core/ipsl_pkg.sv
// ipsl_pkg: shared types, widths, register indexes and reset values
// for the incremental pi speed loop; used by every file in rtl/core
package ipsl_pkg;

  // default fraction widths handed to the top level parameters
  localparam int unsigned GAIN_FRAC_BITS_DEF   = 8;
  localparam int unsigned FILTER_FRAC_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned DRIVE_W  = 16;
  localparam int unsigned ERR_W    = 17;
  localparam int unsigned DIFF_W   = 18;
  localparam int unsigned FILT_W   = 44;
  localparam int unsigned WEIGHT_W = 16;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd3;

  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST     = 16'd3328;
  localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST    = 16'd512;
  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RST = 16'd62259;
  localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST   = 15'd5000;

  // configuration register set
  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [WEIGHT_W-1:0] filter_weight;
    logic [LIMIT_W-1:0]  drive_limit;
  } cfg_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_MUL_I,
    OP_ADD_INC,
    OP_RAW,
    OP_MUL_A,
    OP_MUL_BL,
    OP_MUL_BH,
    OP_ADD_B,
    OP_B_TRUNC,
    OP_FILT,
    OP_VAL,
    OP_CLAMP
  } dp_op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_I,
    ST_ADD_INC,
    ST_RAW,
    ST_MUL_A,
    ST_MUL_BL,
    ST_MUL_BH,
    ST_ADD_B,
    ST_B_TRUNC,
    ST_FILT,
    ST_VAL,
    ST_CLAMP
  } ctrl_st_e;

endpackage

>>> rtl/core/ipsl_regs.sv
// ipsl_regs: configuration registers written through the plain write port
// depends on ipsl_pkg
module ipsl_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ipsl_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output ipsl_pkg::cfg_t                      cfg_o
);

  ipsl_pkg::cfg_t cfg_q, cfg_d;

  // decode register index, writes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        ipsl_pkg::REG_PROP_GAIN:     cfg_d.prop_gain     = cfg_wdata_i;
        ipsl_pkg::REG_INTEG_GAIN:    cfg_d.integ_gain    = cfg_wdata_i;
        ipsl_pkg::REG_FILTER_WEIGHT: cfg_d.filter_weight = cfg_wdata_i;
        ipsl_pkg::REG_DRIVE_LIMIT:   cfg_d.drive_limit   = cfg_wdata_i[ipsl_pkg::LIMIT_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= ipsl_pkg::PROP_GAIN_RST;
      cfg_q.integ_gain    <= ipsl_pkg::INTEG_GAIN_RST;
      cfg_q.filter_weight <= ipsl_pkg::FILTER_WEIGHT_RST;
      cfg_q.drive_limit   <= ipsl_pkg::DRIVE_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/ipsl_ctrl.sv
// ipsl_ctrl: sequencer that steps the datapath through one sample and
// owns the stream handshakes; depends on ipsl_pkg
module ipsl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ipsl_pkg::dp_op_e    op_o
);

  ipsl_pkg::ctrl_st_e state_q, state_d;
  logic               out_vld_q, out_vld_d;
  logic               out_load;

  // state register and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ipsl_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // next state and datapath command
  always_comb begin
    state_d  = state_q;
    op_o     = ipsl_pkg::OP_NONE;
    out_load = 1'b0;
    case (state_q)
      ipsl_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = ipsl_pkg::OP_LOAD;
          state_d = ipsl_pkg::ST_MUL_P;
        end
      end
      ipsl_pkg::ST_MUL_P: begin
        op_o    = ipsl_pkg::OP_MUL_P;
        state_d = ipsl_pkg::ST_MUL_I;
      end
      ipsl_pkg::ST_MUL_I: begin
        op_o    = ipsl_pkg::OP_MUL_I;
        state_d = ipsl_pkg::ST_ADD_INC;
      end
      ipsl_pkg::ST_ADD_INC: begin
        op_o    = ipsl_pkg::OP_ADD_INC;
        state_d = ipsl_pkg::ST_RAW;
      end
      ipsl_pkg::ST_RAW: begin
        op_o    = ipsl_pkg::OP_RAW;
        state_d = ipsl_pkg::ST_MUL_A;
      end
      ipsl_pkg::ST_MUL_A: begin
        op_o    = ipsl_pkg::OP_MUL_A;
        state_d = ipsl_pkg::ST_MUL_BL;
      end
      ipsl_pkg::ST_MUL_BL: begin
        op_o    = ipsl_pkg::OP_MUL_BL;
        state_d = ipsl_pkg::ST_MUL_BH;
      end
      ipsl_pkg::ST_MUL_BH: begin
        op_o    = ipsl_pkg::OP_MUL_BH;
        state_d = ipsl_pkg::ST_ADD_B;
      end
      ipsl_pkg::ST_ADD_B: begin
        op_o    = ipsl_pkg::OP_ADD_B;
        state_d = ipsl_pkg::ST_B_TRUNC;
      end
      ipsl_pkg::ST_B_TRUNC: begin
        op_o    = ipsl_pkg::OP_B_TRUNC;
        state_d = ipsl_pkg::ST_FILT;
      end
      ipsl_pkg::ST_FILT: begin
        op_o    = ipsl_pkg::OP_FILT;
        state_d = ipsl_pkg::ST_VAL;
      end
      ipsl_pkg::ST_VAL: begin
        op_o    = ipsl_pkg::OP_VAL;
        state_d = ipsl_pkg::ST_CLAMP;
      end
      ipsl_pkg::ST_CLAMP: begin
        // wait here while the previous result is still held at the output
        if (!out_vld_q || out_ready_i) begin
          op_o     = ipsl_pkg::OP_CLAMP;
          out_load = 1'b1;
          state_d  = ipsl_pkg::ST_IDLE;
        end
      end
      default: state_d = ipsl_pkg::ST_IDLE;
    endcase
  end

  // output valid holds until the result transfer
  assign out_vld_d = out_load | (out_vld_q & ~out_ready_i);

  assign in_ready_o  = (state_q == ipsl_pkg::ST_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

>>> rtl/core/ipsl_dp.sv
// ipsl_dp: datapath with one shared multiplier, accumulators, loop state
// and the output register; depends on ipsl_pkg
module ipsl_dp #(
  parameter int unsigned GAIN_FRAC_BITS   = ipsl_pkg::GAIN_FRAC_BITS_DEF,
  parameter int unsigned FILTER_FRAC_BITS = ipsl_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ipsl_pkg::dp_op_e                    op_i,
  input  ipsl_pkg::cfg_t                      cfg_i,
  input  logic [ipsl_pkg::SPEED_W-1:0]        target_speed_i,
  input  logic [ipsl_pkg::SPEED_W-1:0]        measured_speed_i,
  output logic [ipsl_pkg::DRIVE_W-1:0]        drive_value_o
);

  localparam int unsigned G      = GAIN_FRAC_BITS;
  localparam int unsigned F      = FILTER_FRAC_BITS;
  localparam int unsigned WB     = ipsl_pkg::WEIGHT_W;
  localparam int unsigned FW     = ipsl_pkg::FILT_W;
  localparam int unsigned FH_W   = FW / 2;
  localparam int unsigned SUM_W  = 36;
  localparam int unsigned INC_W  = SUM_W - G;
  localparam int unsigned RAW_W  = INC_W + 1;
  localparam int unsigned MA_W   = WB + 2;
  localparam int unsigned MB_W   = (RAW_W > FH_W + 1) ? RAW_W : FH_W + 1;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned UP     = (F >= WB) ? F - WB : 0;
  localparam int unsigned DOWN   = (F >= WB) ? 0 : WB - F;
  localparam int unsigned A_W    = PROD_W + UP;
  localparam int unsigned BF_W   = 63;
  localparam int unsigned B_W    = BF_W - WB;
  localparam int unsigned FS_W   = ((A_W > B_W) ? A_W : B_W) + 1;
  localparam int unsigned VAL_W  = FW - F;
  localparam int unsigned ERR_W  = ipsl_pkg::ERR_W;
  localparam int unsigned DIFF_W = ipsl_pkg::DIFF_W;
  localparam int unsigned DRV_W  = ipsl_pkg::DRIVE_W;
  localparam int unsigned LIM_W  = ipsl_pkg::LIMIT_W;
  localparam logic [WB:0] ONE_Q  = (WB + 1)'(1) << WB;

  // loop state
  logic signed [ERR_W-1:0]  prev_err_q, prev_err_d;
  logic signed [DRV_W-1:0]  held_q, held_d;
  logic signed [FW-1:0]     fm_q, fm_d;
  // working registers
  logic signed [ERR_W-1:0]  err_q, err_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [SUM_W-1:0]  acc_q, acc_d;
  logic signed [RAW_W-1:0]  raw_q, raw_d;
  logic signed [A_W-1:0]    a_q, a_d;
  logic signed [BF_W-1:0]   bsum_q, bsum_d;
  logic signed [B_W-1:0]    b_q, b_d;
  logic signed [VAL_W-1:0]  val_q, val_d;
  logic [DRV_W-1:0]         out_q, out_d;

  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] mul_res;
  logic [WB:0]              omw;
  logic signed [ERR_W-1:0]  err_new;
  logic signed [SUM_W-1:0]  acc_bias;
  logic signed [INC_W-1:0]  inc;
  logic signed [A_W-1:0]    a_term;
  logic signed [BF_W-1:0]   b_bias;
  logic signed [FS_W-1:0]   fs;
  logic                     fs_ovf;
  logic signed [FW-1:0]     fm_bias;
  logic signed [VAL_W-1:0]  lim;
  logic signed [VAL_W-1:0]  clamped;

  assign omw = ONE_Q - {1'b0, cfg_i.filter_weight};

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (op_i)
      ipsl_pkg::OP_MUL_P: begin
        ma = MA_W'({1'b0, cfg_i.prop_gain});
        mb = MB_W'(diff_q);
      end
      ipsl_pkg::OP_MUL_I: begin
        ma = MA_W'({1'b0, cfg_i.integ_gain});
        mb = MB_W'(err_q);
      end
      ipsl_pkg::OP_MUL_A: begin
        ma = MA_W'({1'b0, cfg_i.filter_weight});
        mb = MB_W'(raw_q);
      end
      ipsl_pkg::OP_MUL_BL: begin
        ma = MA_W'({1'b0, omw});
        mb = MB_W'({1'b0, fm_q[FH_W-1:0]});
      end
      ipsl_pkg::OP_MUL_BH: begin
        ma = MA_W'({1'b0, omw});
        mb = MB_W'($signed(fm_q[FW-1:FH_W]));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_res = ma * mb;

  // error and increment, truncated toward zero
  assign err_new  = ERR_W'($signed(target_speed_i)) - ERR_W'($signed(measured_speed_i));
  assign acc_bias = acc_q + $signed({{(SUM_W-G){1'b0}}, {G{acc_q[SUM_W-1]}}});
  assign inc      = $signed(acc_bias[SUM_W-1:G]);

  // weighted raw term scaled to the filter fraction
  if (DOWN > 0) begin : g_down
    logic signed [PROD_W-1:0] pb;
    assign pb     = prod_q + $signed({{(PROD_W-DOWN){1'b0}}, {DOWN{prod_q[PROD_W-1]}}});
    assign a_term = A_W'($signed(pb[PROD_W-1:DOWN]));
  end else begin : g_up
    assign a_term = A_W'(prod_q) <<< UP;
  end

  // filter memory term divided by 2^16 toward zero
  assign b_bias = bsum_q + $signed({{(BF_W-WB){1'b0}}, {WB{bsum_q[BF_W-1]}}});

  // filter sum with saturation to the state width
  assign fs     = FS_W'(a_q) + FS_W'(b_q);
  assign fs_ovf = ~((&fs[FS_W-1:FW-1]) | ~(|fs[FS_W-1:FW-1]));

  // filter state to integer, then clamp
  assign fm_bias = fm_q + $signed({{(FW-F){1'b0}}, {F{fm_q[FW-1]}}});
  assign lim     = $signed({{(VAL_W-LIM_W){1'b0}}, cfg_i.drive_limit});

  always_comb begin
    if (val_q >= lim) begin
      clamped = lim;
    end else if (val_q <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = val_q;
    end
  end

  // per-operation register updates
  always_comb begin
    prev_err_d = prev_err_q;
    held_d     = held_q;
    fm_d       = fm_q;
    err_d      = err_q;
    diff_d     = diff_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    raw_d      = raw_q;
    a_d        = a_q;
    bsum_d     = bsum_q;
    b_d        = b_q;
    val_d      = val_q;
    out_d      = out_q;
    case (op_i)
      ipsl_pkg::OP_LOAD: begin
        err_d  = err_new;
        diff_d = DIFF_W'(err_new) - DIFF_W'(prev_err_q);
      end
      ipsl_pkg::OP_MUL_P: prod_d = mul_res;
      ipsl_pkg::OP_MUL_I: begin
        prod_d = mul_res;
        acc_d  = SUM_W'(prod_q);
      end
      ipsl_pkg::OP_ADD_INC: acc_d = acc_q + SUM_W'(prod_q);
      ipsl_pkg::OP_RAW:     raw_d = RAW_W'(held_q) + RAW_W'(inc);
      ipsl_pkg::OP_MUL_A:   prod_d = mul_res;
      ipsl_pkg::OP_MUL_BL: begin
        prod_d = mul_res;
        a_d    = a_term;
      end
      ipsl_pkg::OP_MUL_BH: begin
        prod_d = mul_res;
        bsum_d = BF_W'(prod_q);
      end
      ipsl_pkg::OP_ADD_B:   bsum_d = bsum_q + (BF_W'(prod_q) <<< FH_W);
      ipsl_pkg::OP_B_TRUNC: b_d = $signed(b_bias[BF_W-1:WB]);
      ipsl_pkg::OP_FILT: begin
        fm_d = fs_ovf ? {fs[FS_W-1], {(FW-1){~fs[FS_W-1]}}} : fs[FW-1:0];
      end
      ipsl_pkg::OP_VAL:     val_d = $signed(fm_bias[FW-1:F]);
      ipsl_pkg::OP_CLAMP: begin
        held_d     = clamped[DRV_W-1:0];
        prev_err_d = err_q;
        out_d      = clamped[DRV_W-1:0];
      end
      default: begin
        err_d = err_q;
      end
    endcase
  end

  // loop state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      held_q     <= '0;
      fm_q       <= '0;
    end else begin
      prev_err_q <= prev_err_d;
      held_q     <= held_d;
      fm_q       <= fm_d;
    end
  end

  // working and output registers
  always_ff @(posedge clk_i) begin
    err_q  <= err_d;
    diff_q <= diff_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    raw_q  <= raw_d;
    a_q    <= a_d;
    bsum_q <= bsum_d;
    b_q    <= b_d;
    val_q  <= val_d;
    out_q  <= out_d;
  end

  assign drive_value_o = out_q;

endmodule

>>> rtl/core/incremental_pi_speed_loop_core.sv
// incremental pi speed loop, one wheel, with low-pass filtered drive output
// per sample the sequencer steps the states mul_p through val on one shared multiplier,
// then clamp loads the output register, waiting while it still holds an untaken result;
// inputs are taken only in idle, even while a finished result waits at the output register
// reset: asynchronous active low, clears loop state and loads register defaults
// depends on ipsl_pkg, ipsl_regs, ipsl_ctrl, ipsl_dp
module incremental_pi_speed_loop_core #(
  parameter int unsigned GAIN_FRAC_BITS   = ipsl_pkg::GAIN_FRAC_BITS_DEF,
  parameter int unsigned FILTER_FRAC_BITS = ipsl_pkg::FILTER_FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // target_speed, measured_speed
  // output stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [15:0]                      m_axis_tdata,  // drive_value
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [ipsl_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ipsl_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  ipsl_pkg::cfg_t   cfg;
  ipsl_pkg::dp_op_e op;

  // configuration registers
  ipsl_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer
  ipsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .op_o        (op)
  );

  // datapath
  ipsl_dp #(
    .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
    .FILTER_FRAC_BITS (FILTER_FRAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .cfg_i            (cfg),
    .target_speed_i   (s_axis_tdata[15:0]),
    .measured_speed_i (s_axis_tdata[31:16]),
    .drive_value_o    (m_axis_tdata)
  );

endmodule
